// ----- design/urxbd_pkg.sv -----
// ----------------------------------------------------------------------------
// urxbd_pkg
// Shared types and constants for the UART receiver with line-break detection.
// ----------------------------------------------------------------------------
`default_nettype none

package urxbd_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_NOISE = 2'd1,
        ST_BREAK = 2'd2,
        ST_FRAME = 2'd3
    } status_t;

    // Configuration register indexes.
    localparam logic [7:0] CFG_BIT_TICKS      = 8'd0;
    localparam logic [7:0] CFG_HALF_BIT_TICKS = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [7:0] BIT_TICKS_RESET      = 8'd16;
    localparam logic [7:0] HALF_BIT_TICKS_RESET = 8'd8;

    // Data bits per frame.
    localparam logic [3:0] DATA_BITS = 4'd9 - 4'd1;

    // One step's outcome, handed from the frame engine to the result register.
    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [7:0] rx_byte;
    } res_t;

endpackage

`default_nettype wire

// ----- design/urxbd_core.sv -----
// ----------------------------------------------------------------------------
// urxbd_core
// Frame engine: tracks the frame phase, the tick countdown and the data shift
// register, and reports the outcome of one sample tick.
// ----------------------------------------------------------------------------
`default_nettype none

module urxbd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire logic            level,
    input  wire logic [7:0]      bit_ticks,
    input  wire logic [7:0]      half_bit_ticks,
    output urxbd_pkg::res_t      res
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic [7:0] cnt_reg,    cnt_next;
    logic [3:0] bits_reg,   bits_next;
    logic [7:0] shift_reg,  shift_next;
    logic       sample_now;

    // A countdown of zero or one means the sample point is this tick.
    assign sample_now = (cnt_reg <= 8'd1);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        res        = '0;
        res.status = urxbd_pkg::ST_DATA;

        if (step_en)
        begin
            if (phase_reg != PH_IDLE && !sample_now)
            begin
                cnt_next = cnt_reg - 8'd1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (!level)
                        begin
                            phase_next = PH_START;
                            cnt_next   = half_bit_ticks;
                        end
                    end
                    PH_START:
                    begin
                        if (level)
                        begin
                            phase_next = PH_IDLE;
                            cnt_next   = 8'd0;
                            res.valid  = 1'b1;
                            res.status = urxbd_pkg::ST_NOISE;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            bits_next  = urxbd_pkg::DATA_BITS;
                            shift_next = 8'd0;
                            cnt_next   = bit_ticks;
                        end
                    end
                    PH_DATA:
                    begin
                        shift_next = {level, shift_reg[7:1]};
                        bits_next  = bits_reg - 4'd1;
                        if (bits_next == 4'd0)
                        begin
                            phase_next = PH_STOP;
                        end
                        cnt_next = bit_ticks;
                    end
                    PH_STOP:
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = 8'd0;
                        res.valid  = 1'b1;
                        if (level)
                        begin
                            res.status  = urxbd_pkg::ST_DATA;
                            res.rx_byte = shift_reg;
                        end
                        else if (shift_reg == 8'd0)
                        begin
                            res.status = urxbd_pkg::ST_BREAK;
                        end
                        else
                        begin
                            res.status = urxbd_pkg::ST_FRAME;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 8'd0;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/uart_receive_with_break_detect.sv -----
// ----------------------------------------------------------------------------
// uart_receive_with_break_detect
// 8N1 UART receiver fed one line sample per word, with noise, framing-error
// and line-break reporting.
// ----------------------------------------------------------------------------
// Each input word is one oversampled tick of the receive line. The block takes
// one word per clock cycle for as long as the output side keeps up; a word
// is held in the input register, and the frame engine's outcome for it is
// then registered in the output register. The output register and the input
// register decouple the two sides: the input register can take one sample
// while a finished result waits, and only when both registers are full and the
// result is not taken does in_ready drop. A result is produced only on the
// tick that ends a frame: a start bit that reads high at its center (noise),
// or the stop bit (data, line break for a low stop bit after a zero byte,
// framing error otherwise). Configuration registers are bit_ticks
// (index 0) and half_bit_ticks (index 1); writes to other indexes are ignored,
// and the configuration port is always ready.
`default_nettype none

module uart_receive_with_break_detect (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       line_level,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status,
    output logic [7:0]      rx_byte,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic [7:0] bit_ticks_reg;
    logic [7:0] half_bit_ticks_reg;

    // Input register.
    logic       s1_valid_reg;
    logic       s1_level_reg;

    // Result register.
    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic [7:0] out_byte_reg;

    logic            s2_take;
    logic            step_en;
    urxbd_pkg::res_t res;

    // The result register can take a new value when it is empty or being read.
    assign s2_take   = !out_valid_reg || out_ready;
    assign step_en   = s1_valid_reg && s2_take;
    assign in_ready  = !s1_valid_reg || s2_take;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign rx_byte   = out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg      <= urxbd_pkg::BIT_TICKS_RESET;
            half_bit_ticks_reg <= urxbd_pkg::HALF_BIT_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == urxbd_pkg::CFG_BIT_TICKS)
            begin
                bit_ticks_reg <= cfg_data;
            end
            else if (cfg_index == urxbd_pkg::CFG_HALF_BIT_TICKS)
            begin
                half_bit_ticks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_level_reg <= line_level;
        end
    end

    urxbd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_en),
        .level          (s1_level_reg),
        .bit_ticks      (bit_ticks_reg),
        .half_bit_ticks (half_bit_ticks_reg),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_take)
        begin
            out_valid_reg <= step_en && res.valid;
        end
    end

    // Payload is only loaded when a new result is captured.
    always_ff @(posedge clk)
    begin
        if (step_en && res.valid)
        begin
            out_status_reg <= res.status;
            out_byte_reg   <= res.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ----- design/urxbd_checker.sv -----
// ----------------------------------------------------------------------------
// urxbd_checker
// Port-level checks for the UART receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module urxbd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] status,
    input wire logic [7:0] rx_byte
);

    // A waiting result word holds its payload until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(rx_byte))
        else $error("result word changed while stalled");

    // Only a data result carries a byte.
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != urxbd_pkg::ST_DATA) |-> rx_byte == 8'd0)
        else $error("nonzero byte on a non-data result");

    // A fresh result comes from a previously accepted input word.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching input word");

    // Input back-pressure only happens when the output is stalled.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind uart_receive_with_break_detect urxbd_checker u_urxbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .rx_byte   (rx_byte)
);

`default_nettype wire
